[hw/rtl/qenc_pkg.sv]
package qenc_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int PIN_WIDTH        = 8;
  localparam int PIN_CHANNELS     = PIN_WIDTH / 2;
  localparam int COUNT_WIDTH      = 8;
  localparam int SEL_WIDTH        = 2;

  localparam logic [COUNT_WIDTH-1:0] CENTER_COUNT = 8'd128;
  localparam logic [COUNT_WIDTH-1:0] MAX_COUNT    = 8'd255;
  localparam logic [COUNT_WIDTH-1:0] MIN_COUNT    = 8'd1;

  localparam logic CMD_SAMPLE   = 1'b0;
  localparam logic CMD_RECENTER = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [PIN_WIDTH-1:0]   pin_levels;
    logic [SEL_WIDTH-1:0]   channel;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count_ch0;
    logic [COUNT_WIDTH-1:0] count_ch1;
    logic [COUNT_WIDTH-1:0] count_ch2;
    logic [COUNT_WIDTH-1:0] count_ch3;
    logic                   changed;
  } res_t;

  typedef struct packed {
    logic a;
    logic b;
  } ab_t;

endpackage

[hw/rtl/qenc_chan.sv]
module qenc_chan (
  input  logic [qenc_pkg::COUNT_WIDTH-1:0] count,
  input  qenc_pkg::ab_t                    levels_was,
  input  qenc_pkg::ab_t                    levels_now,
  output logic [qenc_pkg::COUNT_WIDTH-1:0] count_step
);

  logic same;
  logic a_moved;
  logic b_moved;
  logic one_moved;
  logic up;

  assign same      = (levels_now.a == levels_now.b);
  assign a_moved   = (levels_was.a != levels_now.a);
  assign b_moved   = (levels_was.b != levels_now.b);
  assign one_moved = a_moved ^ b_moved;
  assign up        = one_moved && (same ? b_moved : a_moved);

  always_comb begin
    if (!one_moved) begin
      count_step = count;
    end else if (up) begin
      count_step = (count == qenc_pkg::MAX_COUNT) ? qenc_pkg::MAX_COUNT
                                                  : count + 8'd1;
    end else begin
      count_step = (count == qenc_pkg::MIN_COUNT) ? qenc_pkg::MIN_COUNT
                                                  : count - 8'd1;
    end
  end

endmodule

[hw/rtl/quad_encoder_sat_counters.sv]
// Quadrature decoder for up to four encoders with saturating 1..255 counts.
// Command channel (cmd_valid / cmd_stall / cmd): a sample beat carries the
// A/B pin levels of channels 0..3; a recenter beat sets one count to 128.
// Result channel (res_valid / res_stall / res): one beat per command with
// the four counts and a changed flag, raised when the counts differ from
// the last set reported as changed (the interrupt request).
// A command taken into the command register moves on into the result
// register when res is free. Throughput: one command per cycle while
// res is not stalled; the decode and the saturating step are combinational
// between the two registers, and state is updated as a command moves across.
// Reset: counts and reported counts go to 128, old pin levels to 0, both
// registers empty. While res_stall holds a result, one more command is
// held in the command register and cmd_stall then rises; nothing is lost.
// Channels above four have no pins, so their counts stay at 128; they join
// the changed compare but have no count field; missing channels read 128.
module quad_encoder_sat_counters #(
  parameter int NUM_CHANNELS = qenc_pkg::NUM_CHANNELS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  qenc_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output qenc_pkg::res_t  res
);

  localparam int CW = qenc_pkg::COUNT_WIDTH;

  logic           cmd_q_valid;
  qenc_pkg::cmd_t cmd_q;
  logic           advance;
  logic           fire;

  logic [CW-1:0]  counts       [NUM_CHANNELS];
  logic [CW-1:0]  reported     [NUM_CHANNELS];
  logic [CW-1:0]  counts_next  [NUM_CHANNELS];
  qenc_pkg::ab_t  levels       [NUM_CHANNELS];
  qenc_pkg::ab_t  levels_now   [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] diff;
  logic           changed_next;
  logic [CW-1:0]  out_counts   [4];
  logic           is_sample;

  assign advance   = !res_valid || !res_stall;
  assign fire      = cmd_q_valid && advance;
  assign cmd_stall = cmd_q_valid && !advance;
  assign is_sample = (cmd_q.command == qenc_pkg::CMD_SAMPLE);

  for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_ch
    logic [CW-1:0] count_step;
    logic          hit;

    if (ch < qenc_pkg::PIN_CHANNELS) begin : g_pins
      assign levels_now[ch].a = cmd_q.pin_levels[2*ch];
      assign levels_now[ch].b = cmd_q.pin_levels[2*ch+1];
      assign hit = (cmd_q.channel == qenc_pkg::SEL_WIDTH'(ch));
    end else begin : g_nopins
      assign levels_now[ch] = '0;
      assign hit = 1'b0;
    end

    qenc_chan u_chan (
      .count      (counts[ch]),
      .levels_was (levels[ch]),
      .levels_now (levels_now[ch]),
      .count_step (count_step)
    );

    always_comb begin
      if (is_sample) begin
        counts_next[ch] = count_step;
      end else if (hit) begin
        counts_next[ch] = qenc_pkg::CENTER_COUNT;
      end else begin
        counts_next[ch] = counts[ch];
      end
    end

    assign diff[ch] = (counts_next[ch] != reported[ch]);
  end

  assign changed_next = |diff;

  for (genvar k = 0; k < 4; k++) begin : g_out
    if (k < NUM_CHANNELS) begin : g_live
      assign out_counts[k] = counts_next[k];
    end else begin : g_fixed
      assign out_counts[k] = qenc_pkg::CENTER_COUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
      res_valid   <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts[i]   <= qenc_pkg::CENTER_COUNT;
        reported[i] <= qenc_pkg::CENTER_COUNT;
        levels[i]   <= '0;
      end
    end else begin
      if (!cmd_q_valid || advance) begin
        cmd_q_valid <= cmd_valid;
      end
      if (advance) begin
        res_valid <= cmd_q_valid;
      end
      if (fire) begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          counts[i] <= counts_next[i];
          if (is_sample) begin
            levels[i] <= levels_now[i];
          end
          if (changed_next) begin
            reported[i] <= counts_next[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      cmd_q <= cmd;
    end
    if (fire) begin
      res.count_ch0 <= out_counts[0];
      res.count_ch1 <= out_counts[1];
      res.count_ch2 <= out_counts[2];
      res.count_ch3 <= out_counts[3];
      res.changed   <= changed_next;
    end
  end

endmodule

[hw/rtl/qenc_checker.sv]
module qenc_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input qenc_pkg::cmd_t cmd,
  input logic           res_valid,
  input logic           res_stall,
  input qenc_pkg::res_t res
);

  // held result beat stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

  a_cmd_reaches_res: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |-> ##2 res_valid)
    else $error("accepted command produced no result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.count_ch0 != 8'd0 && res.count_ch1 != 8'd0 &&
                  res.count_ch2 != 8'd0 && res.count_ch3 != 8'd0)
    else $error("count left its range");

endmodule

bind quad_encoder_sat_counters qenc_checker u_qenc_checker (.*);
